// ===== hdl/rva_pkg.sv =====
// Package for the RGB vibrance adjuster: request types, widths and divider constants.
`timescale 1ns / 1ps

package rva_pkg;

    localparam int CH_W        = 8;   // one colour channel
    localparam int SPREAD_W    = 9;   // 3*max - sum, 0..510
    localparam int M_W         = 17;  // (max - c) * spread, up to 130050
    localparam int N_W         = 24;  // times |strength|, up to 16646400
    localparam int RECIP_W     = 25;
    localparam int PROD_W      = N_W + RECIP_W;
    localparam int RECIP_SHIFT = 40;
    localparam int Q_W         = 9;   // quotient, up to 435
    localparam int SUM_W       = 11;  // signed channel plus delta
    localparam int NUM_CH      = 3;

    // floor(n / 38250) == (n * RECIP) >> 40 for every n below 2**24
    localparam logic [RECIP_W-1:0] RECIP = 25'd28745403;
    localparam logic [Q_W-1:0]     Q_MAX = 9'd435;

    localparam int PADDR_W = 3;
    localparam logic REG_STRENGTH = 1'b0;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic            last_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            last_out;
    } pix_out_t;

endpackage

// ===== hdl/rgb_vibrance_adjust.sv =====
// Vibrance adjustment of an RGB888 pixel stream, five-stage pipeline with APB strength register.
// Throughput: one pixel per cycle while res is not stalled; every stage holds its own valid bit and a bubble
// closes up while the output is stalled.
// Reset: rst_n clears all valid bits and sets strength to zero; pixel data is not reset.
`timescale 1ns / 1ps

module rgb_vibrance_adjust
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  rva_pkg::pix_in_t               pix,

    output logic                           res_valid,
    input  logic                           res_stall,
    output rva_pkg::pix_out_t              res,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rva_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [rva_pkg::CH_W-1:0]     strength_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    logic [rva_pkg::CH_W-1:0]     c1_reg [rva_pkg::NUM_CH];
    logic [rva_pkg::CH_W-1:0]     d1_reg [rva_pkg::NUM_CH];
    logic [rva_pkg::SPREAD_W-1:0] spread1_reg;
    logic                         last1_reg;

    logic [rva_pkg::CH_W-1:0]     c2_reg [rva_pkg::NUM_CH];
    logic [rva_pkg::M_W-1:0]      m2_reg [rva_pkg::NUM_CH];
    logic                         last2_reg;

    logic [rva_pkg::CH_W-1:0]     c3_reg [rva_pkg::NUM_CH];
    logic [rva_pkg::N_W-1:0]      n3_reg [rva_pkg::NUM_CH];
    logic                         neg3_reg;
    logic                         last3_reg;

    logic [rva_pkg::CH_W-1:0]     c4_reg [rva_pkg::NUM_CH];
    logic [rva_pkg::Q_W-1:0]      q4_reg [rva_pkg::NUM_CH];
    logic                         neg4_reg;
    logic                         last4_reg;

    rva_pkg::pix_out_t            res_reg;

    logic [rva_pkg::CH_W-1:0]     c1_next [rva_pkg::NUM_CH];
    logic [rva_pkg::CH_W-1:0]     d1_next [rva_pkg::NUM_CH];
    logic [rva_pkg::SPREAD_W-1:0] spread1_next;
    logic [rva_pkg::M_W-1:0]      m2_next [rva_pkg::NUM_CH];
    logic [rva_pkg::N_W-1:0]      n3_next [rva_pkg::NUM_CH];
    logic [rva_pkg::Q_W-1:0]      q4_next [rva_pkg::NUM_CH];
    logic [rva_pkg::CH_W-1:0]     o5_next [rva_pkg::NUM_CH];
    rva_pkg::pix_out_t            res_next;

    logic [rva_pkg::CH_W-1:0]     mx;
    logic [rva_pkg::SPREAD_W:0]   mx3;
    logic [rva_pkg::SPREAD_W:0]   csum;
    logic [rva_pkg::SPREAD_W:0]   spread_w;
    logic [rva_pkg::CH_W-1:0]     s_mag;
    logic [rva_pkg::PROD_W-1:0]   prod [rva_pkg::NUM_CH];
    logic signed [rva_pkg::SUM_W-1:0] vsum [rva_pkg::NUM_CH];

    logic                         cfg_wr;

    // ---- configuration ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rva_pkg::REG_STRENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= '0;
        end
        else if (cfg_wr)
        begin
            strength_reg <= pwdata[rva_pkg::CH_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == rva_pkg::REG_STRENGTH)
        begin
            prdata = {{(32-rva_pkg::CH_W){strength_reg[rva_pkg::CH_W-1]}}, strength_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // ---- flow control ----
    assign adv5      = !v5_reg || !res_stall;
    assign adv4      = !v4_reg || adv5;
    assign adv3      = !v3_reg || adv4;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign pix_stall = !adv1;
    assign res_valid = v5_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= pix_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // ---- stage 1: max, differences, spread ----
    always_comb
    begin
        c1_next[0] = pix.red_in;
        c1_next[1] = pix.green_in;
        c1_next[2] = pix.blue_in;
        mx = c1_next[0];
        if (c1_next[1] > mx) mx = c1_next[1];
        if (c1_next[2] > mx) mx = c1_next[2];
        mx3  = ({2'b00, mx} << 1) + {2'b00, mx};
        csum = {2'b00, c1_next[0]} + {2'b00, c1_next[1]} + {2'b00, c1_next[2]};
        spread_w = mx3 - csum;
        spread1_next = spread_w[rva_pkg::SPREAD_W-1:0];
        for (int i = 0; i < rva_pkg::NUM_CH; i++)
        begin
            d1_next[i] = mx - c1_next[i];
        end
    end

    // ---- stage 2: (max - c) * spread ----
    always_comb
    begin
        for (int i = 0; i < rva_pkg::NUM_CH; i++)
        begin
            m2_next[i] = {1'b0, d1_reg[i]} * {{(rva_pkg::M_W-rva_pkg::SPREAD_W){1'b0}}, spread1_reg};
        end
    end

    // ---- stage 3: times |strength| ----
    always_comb
    begin
        s_mag = strength_reg[rva_pkg::CH_W-1] ? (~strength_reg + 8'd1) : strength_reg;
        for (int i = 0; i < rva_pkg::NUM_CH; i++)
        begin
            n3_next[i] = rva_pkg::N_W'({m2_reg[i], 8'd0} >> 8) * rva_pkg::N_W'(s_mag);
        end
    end

    // ---- stage 4: divide by 38250 through the reciprocal ----
    always_comb
    begin
        for (int i = 0; i < rva_pkg::NUM_CH; i++)
        begin
            prod[i]    = {{rva_pkg::RECIP_W{1'b0}}, n3_reg[i]}
                       * {{rva_pkg::N_W{1'b0}}, rva_pkg::RECIP};
            q4_next[i] = prod[i][rva_pkg::RECIP_SHIFT +: rva_pkg::Q_W];
        end
    end

    // ---- stage 5: apply sign, add and clamp ----
    always_comb
    begin
        for (int i = 0; i < rva_pkg::NUM_CH; i++)
        begin
            if (neg4_reg)
            begin
                vsum[i] = $signed({3'b000, c4_reg[i]}) + $signed({2'b00, q4_reg[i]});
            end
            else
            begin
                vsum[i] = $signed({3'b000, c4_reg[i]}) - $signed({2'b00, q4_reg[i]});
            end
            priority if (vsum[i] < 0)
            begin
                o5_next[i] = '0;
            end
            else if (vsum[i] > 255)
            begin
                o5_next[i] = '1;
            end
            else
            begin
                o5_next[i] = vsum[i][rva_pkg::CH_W-1:0];
            end
        end
        res_next.red_out   = o5_next[0];
        res_next.green_out = o5_next[1];
        res_next.blue_out  = o5_next[2];
        res_next.last_out  = last4_reg;
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (adv1 && pix_valid)
        begin
            c1_reg      <= c1_next;
            d1_reg      <= d1_next;
            spread1_reg <= spread1_next;
            last1_reg   <= pix.last_in;
        end
        if (adv2 && v1_reg)
        begin
            c2_reg    <= c1_reg;
            m2_reg    <= m2_next;
            last2_reg <= last1_reg;
        end
        if (adv3 && v2_reg)
        begin
            c3_reg    <= c2_reg;
            n3_reg    <= n3_next;
            neg3_reg  <= strength_reg[rva_pkg::CH_W-1];
            last3_reg <= last2_reg;
        end
        if (adv4 && v3_reg)
        begin
            c4_reg    <= c3_reg;
            q4_reg    <= q4_next;
            neg4_reg  <= neg3_reg;
            last4_reg <= last3_reg;
        end
        if (adv5 && v4_reg)
        begin
            res_reg <= res_next;
        end
    end

    // ---- assertions ----
    a_max_has_zero_diff: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (d1_reg[0] == '0 || d1_reg[1] == '0 || d1_reg[2] == '0))
        else $error("no channel equals the maximum");

    a_spread_is_diff_sum: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ({1'b0, spread1_reg} ==
                    ({2'b00, d1_reg[0]} + {2'b00, d1_reg[1]} + {2'b00, d1_reg[2]})))
        else $error("spread disagrees with channel differences");

    a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (q4_reg[0] <= rva_pkg::Q_MAX && q4_reg[1] <= rva_pkg::Q_MAX
                    && q4_reg[2] <= rva_pkg::Q_MAX))
        else $error("reciprocal divide out of range");

endmodule

// ===== test/rgb_vibrance_adjust_test.sv =====
// Testbench for rgb_vibrance_adjust: directed and random pixels checked against a vibrance predictor.
`timescale 1ns / 1ps

module rgb_vibrance_adjust_test;

    localparam int PHASE_LEN  = 120;
    localparam int NUM_PHASES = 9;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 10;
    localparam int ADDR_W     = rva_pkg::PADDR_W;
    localparam logic [ADDR_W-1:0] STRENGTH_ADDR = ADDR_W'(4 * rva_pkg::REG_STRENGTH);

    typedef struct {
        int                strength;
        rva_pkg::pix_in_t  pixel;
        bit                known;
        rva_pkg::pix_out_t result;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                pix_valid;
    logic                pix_stall;
    rva_pkg::pix_in_t    pix;
    logic                res_valid;
    logic                res_stall;
    rva_pkg::pix_out_t   res;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    rva_pkg::pix_out_t   pending_pixels[$];
    rva_pkg::pix_out_t   want_pix;
    logic signed [7:0]   strength_now = 8'sd0;
    int                  errors = 0;
    int                  idle_cycles = 0;
    int                  phase_strengths[NUM_PHASES];

    // extremes, grey pixels and clamping at both ends
    stim_row_t directed_rows[23] = '{
        '{   0, {8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{   0, {8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, {8'd255, 8'd255, 8'd255, 1'b1} },
        '{   0, {8'd255, 8'd0,   8'd0,   1'b0}, 1'b1, {8'd255, 8'd0,   8'd0,   1'b0} },
        '{   0, {8'd12,  8'd200, 8'd77,  1'b1}, 1'b1, {8'd12,  8'd200, 8'd77,  1'b1} },
        '{ 127, {8'd255, 8'd0,   8'd0,   1'b0}, 1'b1, {8'd255, 8'd0,   8'd0,   1'b0} },
        '{ 127, {8'd0,   8'd255, 8'd0,   1'b1}, 1'b1, {8'd0,   8'd255, 8'd0,   1'b1} },
        '{ 127, {8'd0,   8'd0,   8'd255, 1'b0}, 1'b1, {8'd0,   8'd0,   8'd255, 1'b0} },
        '{ 127, {8'd128, 8'd128, 8'd128, 1'b1}, 1'b1, {8'd128, 8'd128, 8'd128, 1'b1} },
        '{ 127, {8'd200, 8'd100, 8'd50,  1'b0}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{ 127, {8'd1,   8'd2,   8'd3,   1'b1}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{-128, {8'd255, 8'd0,   8'd0,   1'b1}, 1'b1, {8'd255, 8'd255, 8'd255, 1'b1} },
        '{-128, {8'd0,   8'd0,   8'd255, 1'b0}, 1'b1, {8'd255, 8'd255, 8'd255, 1'b0} },
        '{-128, {8'd90,  8'd90,  8'd90,  1'b1}, 1'b1, {8'd90,  8'd90,  8'd90,  1'b1} },
        '{-128, {8'd250, 8'd10,  8'd130, 1'b0}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{ 100, {8'd255, 8'd254, 8'd0,   1'b0}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{ 100, {8'd10,  8'd240, 8'd30,  1'b1}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{ 100, {8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{-100, {8'd255, 8'd0,   8'd0,   1'b0}, 1'b1, {8'd255, 8'd255, 8'd255, 1'b0} },
        '{-100, {8'd60,  8'd180, 8'd120, 1'b1}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{-100, {8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, {8'd255, 8'd255, 8'd255, 1'b1} },
        '{   1, {8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{   1, {8'd200, 8'd100, 8'd50,  1'b0}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} },
        '{  -1, {8'd200, 8'd100, 8'd50,  1'b1}, 1'b0, {8'd0,   8'd0,   8'd0,   1'b0} }
    };

    rgb_vibrance_adjust i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rva_pkg::pix_out_t vibrance_of(rva_pkg::pix_in_t p, logic signed [7:0] s);
        longint            ch[3];
        longint            mx;
        longint            spread;
        longint            v;
        logic [7:0]        adj[3];
        rva_pkg::pix_out_t r;
        ch[0] = p.red_in;
        ch[1] = p.green_in;
        ch[2] = p.blue_in;
        mx = ch[0];
        if (ch[1] > mx)
        begin
            mx = ch[1];
        end
        if (ch[2] > mx)
        begin
            mx = ch[2];
        end
        spread = 3 * mx - (ch[0] + ch[1] + ch[2]);
        for (int i = 0; i < 3; i++)
        begin
            v = ch[i] + (2 * (mx - ch[i]) * spread * (-longint'(s))) / 76500;
            if (v < 0)
            begin
                v = 0;
            end
            if (v > 255)
            begin
                v = 255;
            end
            adj[i] = v[7:0];
        end
        r.red_out   = adj[0];
        r.green_out = adj[1];
        r.blue_out  = adj[2];
        r.last_out  = p.last_in;
        return r;
    endfunction

    function automatic rva_pkg::pix_in_t random_pixel();
        logic [7:0]       ch[3];
        int               kind;
        int               pick;
        rva_pkg::pix_in_t p;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++)
        begin
            ch[i] = 8'($urandom_range(0, 255));
        end
        if (kind < 15)
        begin
            // near-grey
            ch[1] = {ch[0][7:2], 2'($urandom)};
            ch[2] = {ch[0][7:2], 2'($urandom)};
        end
        else if (kind < 40)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                begin
                    ch[i] = 8'd0;
                end
                else if (pick == 1)
                begin
                    ch[i] = 8'd255;
                end
            end
        end
        else if (kind < 50)
        begin
            // red tied to another channel
            ch[$urandom_range(1, 2)] = ch[0];
        end
        p.red_in   = ch[0];
        p.green_in = ch[1];
        p.blue_in  = ch[2];
        p.last_in  = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    task automatic report_field(string name, int want, int got);
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
    endtask

    task automatic send_pixel(rva_pkg::pix_in_t p, bit known, rva_pkg::pix_out_t typed);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 25);
        if (gap != 0)
        begin
            @(negedge clk) pix_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix       <= p;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
        pending_pixels.push_back(known ? typed : vibrance_of(p, strength_now));
    endtask

    task automatic settle();
        @(negedge clk) pix_valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_strength(int value);
        logic signed [7:0] s8;
        s8 = value[7:0];
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STRENGTH_ADDR;
        pwdata  <= {{24{s8[7]}}, s8};
        @(negedge clk) penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        strength_now = s8;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver: runs of acceptance broken by mostly short stalls
    initial
    begin
        int n;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 60) : $urandom_range(0, 6);
            repeat (n) @(negedge clk);
            @(negedge clk) res_stall <= 1'b1;
            n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 25);
            repeat (n - 1) @(negedge clk);
            @(negedge clk) res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, got %h", $time, res);
                errors++;
            end
            else
            begin
                want_pix = pending_pixels.pop_front();
                if (res.red_out !== want_pix.red_out)
                begin
                    report_field("red_out", want_pix.red_out, res.red_out);
                end
                if (res.green_out !== want_pix.green_out)
                begin
                    report_field("green_out", want_pix.green_out, res.green_out);
                end
                if (res.blue_out !== want_pix.blue_out)
                begin
                    report_field("blue_out", want_pix.blue_out, res.blue_out);
                end
                if (res.last_out !== want_pix.last_out)
                begin
                    report_field("last_out", want_pix.last_out, res.last_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("FAIL rgb_vibrance_adjust");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        phase_strengths = '{100, -100, 127, -128, 0, 0, 0, 0, 0};
        for (int i = 5; i < NUM_PHASES - 1; i++)
        begin
            phase_strengths[i] = int'($urandom_range(0, 200)) - 100;
        end
        phase_strengths[NUM_PHASES - 1] = int'($urandom_range(0, 255)) - 128;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].strength != strength_now)
            begin
                set_strength(directed_rows[i].strength);
            end
            send_pixel(directed_rows[i].pixel, directed_rows[i].known, directed_rows[i].result);
        end

        foreach (phase_strengths[p])
        begin
            set_strength(phase_strengths[p]);
            repeat (PHASE_LEN) send_pixel(random_pixel(), 1'b0, '0);
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS rgb_vibrance_adjust");
        end
        else
        begin
            $display("FAIL rgb_vibrance_adjust");
        end
        $finish;
    end

endmodule
